// ===== rtl/core/planar_icon_to_rgb_top_assert.svh =====
// Assertion macros shared by the planar icon converter RTL.
`ifndef PLANAR_ICON_TO_RGB_TOP_ASSERT_SVH
`define PLANAR_ICON_TO_RGB_TOP_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PITR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PITR_ASSERT(label, prop, msg) `PITR_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/pitr_pkg.sv =====
// Package: constants, register indexes and palette for the planar icon converter.
package pitr_pkg;

    localparam int STORE_BYTES_DEF = 8192;
    localparam int MAX_SIDE        = 1024;

    // Worst-case plane byte address: 2 * 128 * 1023 + 1022 * 128 + 127 < 2**19.
    localparam int ADDR_W = 19;
    localparam int PB_W   = 18;

    localparam logic [2:0] CFG_ICON_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_ICON_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DATA_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DATA_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_DATA_PLANES = 3'd4;
    localparam logic [2:0] CFG_DATA_LEFT   = 3'd5;
    localparam logic [2:0] CFG_DATA_TOP    = 3'd6;
    localparam logic [2:0] CFG_PALETTE     = 3'd7;

    localparam logic       MODE_STORE = 1'b0;
    localparam logic [1:0] MAX_GATHER = 2'd3;

    // Clamp a side register to the largest supported side.
    function automatic logic [9:0] side_sat(input logic [9:0] v);
        logic [31:0] wide;
        wide = {22'd0, v};
        if (wide > 32'(MAX_SIDE - 1)) begin
            return 10'(MAX_SIDE - 1);
        end
        return v;
    endfunction

    // Palette lookup: {red, green, blue}.
    function automatic logic [23:0] pal_rgb(input logic ver, input logic [2:0] idx);
        logic [23:0] rgb;
        case (idx)
            3'd0:    rgb = ver ? 24'h959595 : 24'h55AAFF;
            3'd1:    rgb = ver ? 24'h000000 : 24'hFFFFFF;
            3'd2:    rgb = ver ? 24'hFFFFFF : 24'h000000;
            3'd3:    rgb = ver ? 24'h3B67A2 : 24'hFF8800;
            3'd4:    rgb = 24'h7B7B7B;
            3'd5:    rgb = 24'hAFAFAF;
            3'd6:    rgb = 24'hAA907C;
            3'd7:    rgb = 24'hFFA997;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

// ===== rtl/core/planar_icon_to_rgb_top.sv =====
// Top level: planar icon store and pixel-to-RGB converter.
//
// Usage:
//   Items enter on start/busy: an item is taken at a clock edge with start high
//   and busy low. i_mode selects the item kind. A store item writes i_byte_value
//   into the plane store at i_byte_address (addresses past the store are dropped);
//   busy stays low and no result follows. A read item asks for frame pixel
//   (i_pixel_x, i_pixel_y). Busy then stays high through address setup (two
//   small multipliers), the plane gather (one store read per plane for up to
//   three planes, then a wait for the last read's data and a check that the
//   gather is done) and the palette lookup. The result shows on the o_* ports
//   with o_valid high for exactly one cycle; a new item may be started in that
//   cycle. The single store read port sets the gather time.
//   The receiver cannot stall; o_valid is a strobe and must be taken at once.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
//   Reset (i_rst_n low at a clock edge) clears the configuration registers to
//   zero and returns the sequencer to idle. The plane store is not cleared;
//   every byte that a read reaches must be stored first.
module planar_icon_to_rgb_top
    import pitr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [12:0] i_byte_address,
    input  logic [7:0]  i_byte_value,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [2:0]  o_colour_index,
    output logic        o_outside_frame
);

`include "planar_icon_to_rgb_top_assert.svh"

    localparam int AW = $clog2(STORE_BYTES);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_GATHER = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    // Configuration registers.
    logic [9:0] r_icon_width, r_icon_height, r_data_width, r_data_height;
    logic [9:0] r_data_left, r_data_top;
    logic [3:0] r_data_planes;
    logic       r_palette;

    // Control state and its next values.
    logic [1:0] r_state, n_state;
    logic [1:0] r_p, n_p;
    logic       r_pend, n_pend;
    logic       r_valid, n_valid;

    // Per-item payload.
    logic [9:0]        r_x, r_y;
    logic [2:0]        r_col3;
    logic [1:0]        r_nplanes;
    logic              r_out;
    logic [ADDR_W-1:0] r_addr;
    logic [PB_W-1:0]   r_planebytes;
    logic [1:0]        r_pp;
    logic              r_pzero;
    logic [2:0]        r_index;
    logic [7:0]        r_red, r_green, r_blue;
    logic [2:0]        r_cidx;
    logic              r_oframe;

    // Address setup terms.
    logic [9:0]        w_col, w_row;
    logic              w_out_frame, w_in_data;
    logic [10:0]       w_wsum;
    logic [7:0]        w_rowbytes;
    logic [17:0]       w_rowoff;
    logic [ADDR_W-1:0] w_base;
    logic [PB_W-1:0]   w_planebytes;
    logic [1:0]        w_nplanes;

    // Store access.
    logic              w_accept;
    logic              w_we;
    logic [31:0]       w_waddr32, w_raddr32;
    logic              w_issue, w_addr_ok, w_re;
    logic [7:0]        w_rdata;
    logic [23:0]       w_rgb;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;

    // Store item: write at the accept edge, drop addresses past the store.
    assign w_waddr32 = {19'd0, i_byte_address};
    assign w_we      = w_accept && (i_mode == MODE_STORE) && (w_waddr32 < 32'(STORE_BYTES));

    // Address setup from the latched pixel.
    assign w_out_frame  = (r_x >= r_icon_width) || (r_y >= r_icon_height);
    assign w_col        = r_x - r_data_left;
    assign w_row        = r_y - r_data_top;
    assign w_in_data    = (r_x >= r_data_left) && (r_y >= r_data_top) &&
                          (w_col < r_data_width) && (w_row < r_data_height);
    // Row pitch rounds the width up to a 16-pixel word.
    assign w_wsum       = {1'b0, r_data_width} + 11'd15;
    assign w_rowbytes   = {w_wsum[10:4], 1'b0};
    assign w_rowoff     = w_row * w_rowbytes;
    assign w_base       = ADDR_W'(w_rowoff) + ADDR_W'(w_col[9:3]);
    assign w_planebytes = w_rowbytes * r_data_height;
    // Only planes 0..2 reach the colour index.
    assign w_nplanes    = (w_out_frame || !w_in_data) ? 2'd0 :
                          (r_data_planes >= 4'(MAX_GATHER)) ? MAX_GATHER :
                          r_data_planes[1:0];

    // Gather: one plane read issued per cycle.
    assign w_raddr32 = {13'd0, r_addr};
    assign w_addr_ok = (w_raddr32 < 32'(STORE_BYTES));
    assign w_issue   = (r_state == ST_GATHER) && (r_p != r_nplanes);
    assign w_re      = w_issue && w_addr_ok;

    assign w_rgb = pal_rgb(r_palette, r_index);

    pitr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_plane_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr32[AW-1:0]),
        .i_wdata (i_byte_value),
        .i_re    (w_re),
        .i_raddr (w_raddr32[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_pend  = 1'b0;
        n_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_mode != MODE_STORE)) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_p     = 2'd0;
                n_state = ST_GATHER;
            end
            ST_GATHER: begin
                if (w_issue) begin
                    n_p    = r_p + 2'd1;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_p           <= 2'd0;
            r_pend        <= 1'b0;
            r_valid       <= 1'b0;
            r_icon_width  <= 10'd0;
            r_icon_height <= 10'd0;
            r_data_width  <= 10'd0;
            r_data_height <= 10'd0;
            r_data_planes <= 4'd0;
            r_data_left   <= 10'd0;
            r_data_top    <= 10'd0;
            r_palette     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ICON_WIDTH:  r_icon_width  <= side_sat(i_cfg_data);
                    CFG_ICON_HEIGHT: r_icon_height <= side_sat(i_cfg_data);
                    CFG_DATA_WIDTH:  r_data_width  <= side_sat(i_cfg_data);
                    CFG_DATA_HEIGHT: r_data_height <= side_sat(i_cfg_data);
                    CFG_DATA_PLANES: r_data_planes <= i_cfg_data[3:0];
                    CFG_DATA_LEFT:   r_data_left   <= side_sat(i_cfg_data);
                    CFG_DATA_TOP:    r_data_top    <= side_sat(i_cfg_data);
                    CFG_PALETTE:     r_palette     <= i_cfg_data[0];
                    default:         r_palette     <= r_palette;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
        if (r_state == ST_CALC) begin
            r_col3       <= w_col[2:0];
            r_out        <= w_out_frame;
            r_nplanes    <= w_nplanes;
            r_addr       <= w_base;
            r_planebytes <= w_planebytes;
            r_index      <= 3'd0;
        end
        if (w_issue) begin
            // Advance to the same row in the next plane.
            r_addr  <= r_addr + ADDR_W'(r_planebytes);
            r_pp    <= r_p;
            r_pzero <= !w_addr_ok;
        end
        if (r_pend) begin
            // Bytes past the store read as zero; pixels go MSB first.
            r_index[r_pp] <= r_pzero ? 1'b0 : w_rdata[~r_col3];
        end
        if (r_state == ST_FIN) begin
            r_oframe <= r_out;
            r_cidx   <= r_out ? 3'd0 : r_index;
            r_red    <= r_out ? 8'd0 : w_rgb[23:16];
            r_green  <= r_out ? 8'd0 : w_rgb[15:8];
            r_blue   <= r_out ? 8'd0 : w_rgb[7:0];
        end
    end

    assign o_valid         = r_valid;
    assign o_red           = r_red;
    assign o_green         = r_green;
    assign o_blue          = r_blue;
    assign o_colour_index  = r_cidx;
    assign o_outside_frame = r_oframe;

    `PITR_ASSERT(a_fin_strobe, (r_state == ST_FIN) |=> r_valid, "result strobe missing after palette step")
    `PITR_ASSERT(a_read_in_gather, w_re |-> (r_state == ST_GATHER), "store read outside gather")
    `PITR_ASSERT(a_write_idle, w_we |-> (r_state == ST_IDLE), "store write while busy")
    `PITR_ASSERT(a_plane_bound, (r_state == ST_GATHER) |-> (r_p <= r_nplanes), "plane count overrun")
    `PITR_ASSERT(a_outside_zero, (o_valid && o_outside_frame) |-> (o_colour_index == 3'd0), "outside pixel has index")

endmodule

// ===== rtl/core/pitr_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pitr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/planar_icon_to_rgb_top_tb.sv =====
// Self-checking testbench for the planar icon to RGB converter top level.
module planar_icon_to_rgb_top_tb;
    import pitr_pkg::*;

    // Mode code for a pixel read; a store item uses MODE_STORE from the package.
    localparam logic MODE_READ   = ~MODE_STORE;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   PHASE_ITEMS = 72;
    localparam int   RAND_PHASES = 12;

    // One item as it goes out on the command ports.
    typedef struct {
        logic        mode;
        logic [12:0] addr;
        logic [7:0]  value;
        logic [9:0]  x;
        logic [9:0]  y;
    } req_t;

    // One pixel result as it comes back.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [2:0] cidx;
        logic       outside;
    } pixel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_mode = MODE_STORE;
    logic [12:0] i_byte_address = '0;
    logic [7:0]  i_byte_value = '0;
    logic [9:0]  i_pixel_x = '0;
    logic [9:0]  i_pixel_y = '0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_ICON_WIDTH;
    logic [9:0]  i_cfg_data = '0;
    logic        o_valid;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [2:0]  o_colour_index;
    logic        o_outside_frame;

    planar_icon_to_rgb_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_byte_address (i_byte_address),
        .i_byte_value   (i_byte_value),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_colour_index (o_colour_index),
        .o_outside_frame(o_outside_frame)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 0;
    end

    // Register shadow: written only while the block is idle, so the stimulus
    // generator and the pixel predictor share it.
    int frame_w, frame_h, img_w, img_h, img_planes, img_left, img_top, pal_sel;

    // Predicted plane store contents, updated as store items are taken.
    logic [7:0] plane_mem [0:STORE_BYTES_DEF-1];
    // Bytes that some queued store item will have written; reads never
    // reach a byte outside this set.
    bit         byte_known [0:STORE_BYTES_DEF-1];

    req_t   pending_items[$];
    pixel_t want_q[$];
    req_t   on_port;

    int gap_left, no_gap_left;
    int error_count, cycle_count, settings_used;
    int stores_taken, reads_taken, results_seen, outside_seen, high_idx_seen;

    task automatic flag_error(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    function automatic bit in_frame(input int x, input int y);
        return x < frame_w && y < frame_h;
    endfunction

    function automatic bit in_image(input int x, input int y);
        return x >= img_left && y >= img_top && x - img_left < img_w && y - img_top < img_h;
    endfunction

    // Byte that holds plane p of image pixel (col, row); rows are padded to 16 pixels.
    function automatic int plane_byte_addr(input int p, input int col, input int row);
        int rowbytes;
        rowbytes = ((img_w + 15) >> 4) << 1;
        return p * rowbytes * img_h + row * rowbytes + (col >> 3);
    endfunction

    // Two fixed colour sets share entries 4..7; entries 0..3 depend on the version.
    function automatic logic [23:0] colour_of(input int ver, input logic [2:0] idx);
        if (idx[2]) begin
            case (idx[1:0])
                2'd0:    return 24'h7B7B7B;
                2'd1:    return 24'hAFAFAF;
                2'd2:    return 24'hAA907C;
                default: return 24'hFFA997;
            endcase
        end else if (ver != 0) begin
            case (idx[1:0])
                2'd0:    return 24'h959595;
                2'd1:    return 24'h000000;
                2'd2:    return 24'hFFFFFF;
                default: return 24'h3B67A2;
            endcase
        end else begin
            case (idx[1:0])
                2'd0:    return 24'h55AAFF;
                2'd1:    return 24'hFFFFFF;
                2'd2:    return 24'h000000;
                default: return 24'hFF8800;
            endcase
        end
    endfunction

    // Expected colour of frame pixel (x, y) under the current registers and store.
    function automatic pixel_t predict_pixel(input int x, input int y);
        pixel_t     res;
        logic [2:0] idx;
        logic [7:0] b;
        int         p, a, col, row;
        res = '0;
        idx = '0;
        if (!in_frame(x, y)) begin
            res.outside = 1'b1;
            return res;
        end
        if (in_image(x, y)) begin
            col = x - img_left;
            row = y - img_top;
            // Only the first three planes reach the index.
            for (p = 0; p < 3 && p < img_planes; p++) begin
                a = plane_byte_addr(p, col, row);
                b = (a < STORE_BYTES_DEF) ? plane_mem[a] : 8'h00;
                idx[p] = b[7 - (col & 7)];
            end
        end
        {res.red, res.green, res.blue} = colour_of(pal_sel, idx);
        res.cidx = idx;
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a stretch with none.
    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            no_gap_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(5, 40);
    endfunction

    task automatic queue_store(input int a, input int v);
        req_t it;
        it.mode  = MODE_STORE;
        it.addr  = 13'(a);
        it.value = 8'(v);
        it.x     = 10'($urandom);
        it.y     = 10'($urandom);
        byte_known[a] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Queue a pixel read, preceded by stores for any plane byte it would
    // gather that nothing has written yet.
    task automatic queue_read(input int x, input int y);
        req_t it;
        int   p, a;
        if (in_frame(x, y) && in_image(x, y)) begin
            for (p = 0; p < 3 && p < img_planes; p++) begin
                a = plane_byte_addr(p, x - img_left, y - img_top);
                if (a < STORE_BYTES_DEF && !byte_known[a]) begin
                    queue_store(a, $urandom_range(0, 255));
                end
            end
        end
        it.mode  = MODE_READ;
        it.addr  = 13'($urandom);
        it.value = 8'($urandom);
        it.x     = 10'(x);
        it.y     = 10'(y);
        pending_items.push_back(it);
    endtask

    task automatic queue_random_item();
        int r, x, y, limit, gathered;
        r = $urandom_range(0, 99);
        gathered = (img_planes < 3) ? img_planes : 3;
        limit = gathered * (((img_w + 15) >> 4) << 1) * img_h;
        if (limit > STORE_BYTES_DEF) limit = STORE_BYTES_DEF;
        if (r < 20 && limit > 0) begin
            // overwrite a byte the current image uses
            queue_store($urandom_range(0, limit - 1), $urandom_range(0, 255));
        end else if (r < 30) begin
            queue_store($urandom_range(0, STORE_BYTES_DEF - 1), $urandom_range(0, 255));
        end else if (r < 75 && img_w > 0 && img_h > 0) begin
            x = img_left + $urandom_range(0, img_w - 1);
            y = img_top + $urandom_range(0, img_h - 1);
            if (x > 1023) x = $urandom_range(0, 1023);
            if (y > 1023) y = $urandom_range(0, 1023);
            queue_read(x, y);
        end else if (r < 90) begin
            // frame edge included: x == width is just outside
            queue_read($urandom_range(0, frame_w), $urandom_range(0, frame_h));
        end else begin
            queue_read($urandom_range(0, 1023), $urandom_range(0, 1023));
        end
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [9:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ICON_WIDTH:  frame_w    = val;
            CFG_ICON_HEIGHT: frame_h    = val;
            CFG_DATA_WIDTH:  img_w      = val;
            CFG_DATA_HEIGHT: img_h      = val;
            CFG_DATA_PLANES: img_planes = val[3:0];
            CFG_DATA_LEFT:   img_left   = val;
            CFG_DATA_TOP:    img_top    = val;
            CFG_PALETTE:     pal_sel    = val[0];
            default: ;
        endcase
    endtask

    // Write all eight registers; unused upper data bits get random values.
    task automatic apply_config(input int iw, input int ih, input int dw, input int dh,
                                input int np, input int dl, input int dt, input int pv);
        set_reg(CFG_ICON_WIDTH, 10'(iw));
        set_reg(CFG_ICON_HEIGHT, 10'(ih));
        set_reg(CFG_DATA_WIDTH, 10'(dw));
        set_reg(CFG_DATA_HEIGHT, 10'(dh));
        set_reg(CFG_DATA_PLANES, {6'($urandom), 4'(np)});
        set_reg(CFG_DATA_LEFT, 10'(dl));
        set_reg(CFG_DATA_TOP, 10'(dt));
        set_reg(CFG_PALETTE, {9'($urandom), 1'(pv)});
        settings_used++;
    endtask

    // Hold until every queued item is taken and every result is back, then
    // let a store that may still be in flight settle. Sample on the falling
    // edge so that an item launched at the rising edge is already on start.
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge i_clk);
        while (pending_items.size() != 0 || start) @(negedge i_clk);
        while (want_q.size() != 0 && waited < 100) begin
            @(negedge i_clk);
            waited++;
        end
        if (want_q.size() != 0) begin
            flag_error($sformatf("%0d expected results never arrived", want_q.size()));
            want_q.delete();
        end
        repeat (12) @(posedge i_clk);
    endtask

    // Driver: take the item on the ports when start meets busy low, then
    // either hold start for the next item or drop it for a gap.
    always @(posedge i_clk) begin : drive_proc
        req_t nxt;
        logic launch;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            launch = 1'b0;
            if (start && !busy) begin
                if (on_port.mode == MODE_STORE) begin
                    plane_mem[on_port.addr] = on_port.value;
                    stores_taken++;
                end else begin
                    want_q.push_back(predict_pixel(on_port.x, on_port.y));
                    reads_taken++;
                end
                gap_left = pick_gap();
            end
            // a held item stays on the ports until busy drops
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    on_port = nxt;
                    launch = 1'b1;
                    i_mode         <= nxt.mode;
                    i_byte_address <= nxt.addr;
                    i_byte_value   <= nxt.value;
                    i_pixel_x      <= nxt.x;
                    i_pixel_y      <= nxt.y;
                end
                start <= launch;
            end
        end
    end

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 results_seen, name, got, want));
        end
    endtask

    // Monitor: every strobe is matched against the oldest expected pixel.
    always @(posedge i_clk) begin : check_proc
        pixel_t want;
        if (i_rst_n && o_valid) begin
            if (want_q.size() == 0) begin
                flag_error("result strobe with no read item outstanding");
            end else begin
                want = want_q.pop_front();
                check_field("red", o_red, want.red);
                check_field("green", o_green, want.green);
                check_field("blue", o_blue, want.blue);
                check_field("colour_index", o_colour_index, want.cidx);
                check_field("outside_frame", o_outside_frame, want.outside);
                if (want.outside) outside_seen++;
                if (want.cidx[2]) high_idx_seen++;
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int k, x, np, sides;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset registers: the frame is empty, so every read is outside it.
        // Stores hit both ends of the address range.
        queue_store(0, 8'h00);
        queue_store(STORE_BYTES_DEF - 1, 8'hFF);
        queue_read(0, 0);
        queue_read(1023, 1023);
        wait_idle();

        // One 8-pixel row, three planes at bytes 0, 2 and 4; the bit patterns
        // make column c give index c.
        apply_config(32, 16, 8, 1, 3, 4, 2, 0);
        queue_store(0, 8'h55);
        queue_store(2, 8'h33);
        queue_store(4, 8'h0F);
        for (x = 4; x < 12; x++) queue_read(x, 2);
        queue_read(0, 0);      // in frame, left of the image
        queue_read(31, 15);    // in frame, past the image
        queue_read(32, 0);     // one column past the frame
        queue_read(0, 16);     // one row past the frame
        wait_idle();

        // Newer colour set; planes above the third must not matter.
        apply_config(32, 16, 8, 1, 15, 4, 2, 1);
        for (x = 8; x < 12; x++) queue_read(x, 2);
        queue_read(4, 2);
        wait_idle();

        // Largest sides: higher planes and far rows fall past the store.
        apply_config(1023, 1023, 1023, 1023, 3, 0, 0, 0);
        queue_read(0, 0);
        queue_read(1022, 1022);
        queue_read(1023, 0);
        wait_idle();
        apply_config(1023, 1023, 5, 5, 1, 1023, 1023, 1);
        queue_read(1022, 1022);
        wait_idle();

        // Random part: a fresh register setting per phase, mostly small images.
        for (k = 0; k < RAND_PHASES; k++) begin
            np = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(0, 15);
            if (k == 3) begin
                apply_config(1023, 1023, 1023, 1023, $urandom_range(0, 15),
                             $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 1));
            end else if (k == 7) begin
                // empty image: the whole frame shows entry 0
                apply_config(1023, 1023, 0, $urandom_range(0, 20), 3, 0, 0, 0);
            end else if (k == 10) begin
                apply_config(1023, 1023, $urandom_range(1, 64), $urandom_range(1, 32), np,
                             $urandom_range(980, 1023), $urandom_range(980, 1023),
                             $urandom_range(0, 1));
            end else begin
                sides = $urandom_range(0, 7);
                apply_config((sides == 0) ? 1023 : $urandom_range(0, 80),
                             (sides == 1) ? 1023 : $urandom_range(0, 60),
                             $urandom_range(1, 48), $urandom_range(1, 20), np,
                             $urandom_range(0, 24), $urandom_range(0, 24), $urandom_range(0, 1));
            end
            while (pending_items.size() < PHASE_ITEMS) queue_random_item();
            wait_idle();
        end

        $display("Covered %0d store and %0d read items over %0d register settings",
                 stores_taken, reads_taken, settings_used);
        $display("Checked %0d pixels: %0d outside the frame, %0d from the shared upper entries",
                 results_seen, outside_seen, high_idx_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
